@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/kcg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcg_pkg
// Constants and types shared by the k-combination generator.
// ----------------------------------------------------------------------------
package kcg_pkg;

    // Largest value and largest subset size supported.
    localparam int MAX_N = 32;
    localparam int MAX_K = 8;

    // Field widths.
    localparam int EW = 6;              // element / set size / first value
    localparam int KW = 4;              // choose count
    localparam int IW = $clog2(MAX_K);  // position index

    // Stream and register port widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = ((MAX_K * EW + 7) / 8) * 8;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SET_SIZE     = 2'd0;
    localparam logic [1:0] REG_CHOOSE_COUNT = 2'd1;
    localparam logic [1:0] REG_FIRST_VALUE  = 2'd2;

    // Register reset values.
    localparam logic [EW-1:0] SET_SIZE_RST     = EW'(4);
    localparam logic [KW-1:0] CHOOSE_COUNT_RST = KW'(2);
    localparam logic [EW-1:0] FIRST_VALUE_RST  = EW'(1);

    typedef logic [MAX_K-1:0][EW-1:0] elem_vec_t;

    typedef struct packed {
        logic [EW-1:0] set_size;
        logic [KW-1:0] choose_count;
        logic [EW-1:0] first_value;
    } cfg_t;

    typedef struct packed {
        elem_vec_t comb;
        logic      started;
        logic      done;
    } gen_state_t;

    typedef struct packed {
        elem_vec_t elem;
        logic      final_flag;
        logic      status;
    } result_t;

endpackage

@@ hw/rtl/kcg_successor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcg_successor
// Combinational step unit: from the stored combination and the registers it
// forms the first or the next combination, the new state and the result.
// ----------------------------------------------------------------------------
module kcg_successor
    import kcg_pkg::*;
(
    input  cfg_t       cfg,
    input  gen_state_t state,
    input  logic       restart,
    output gen_state_t state_next,
    output result_t    result
);

    localparam int AW = EW + 1;
    localparam int LW = EW + 2;

    logic [EW-1:0] n_eff;
    logic [EW-1:0] lo;
    logic [AW-1:0] avail;
    logic [KW-1:0] k;
    logic          cfg_ok;
    logic [LW-1:0] base;
    logic [LW-1:0] lim       [MAX_K];
    logic [MAX_K-1:0] in_use;
    logic [MAX_K-1:0] can_raise;
    logic [IW-1:0] pivot;
    logic [EW-1:0] piv_val;
    logic          from_start;
    elem_vec_t     cand;
    logic          fin;

    // Effective limits and the check that at least one combination exists.
    always_comb begin
        n_eff  = (cfg.set_size > EW'(MAX_N)) ? EW'(MAX_N) : cfg.set_size;
        lo     = (cfg.first_value == '0) ? EW'(1) : cfg.first_value;
        avail  = (n_eff >= lo) ? (AW'(n_eff) - AW'(lo) + AW'(1)) : '0;
        k      = cfg.choose_count;
        cfg_ok = (k <= KW'(MAX_K)) && (AW'(k) <= avail);
        // Largest value allowed at position 0; position i adds i.
        base   = LW'(n_eff) - LW'(k) + LW'(1);
    end

    // Per-position limits and the rightmost position that can still rise.
    always_comb begin
        pivot = '0;
        for (int i = 0; i < MAX_K; i++) begin
            lim[i]       = base + LW'(i);
            in_use[i]    = KW'(i) < k;
            can_raise[i] = in_use[i] && (LW'(state.comb[i]) < lim[i]);
        end
        for (int i = 0; i < MAX_K; i++) begin
            if (can_raise[i]) begin
                pivot = IW'(i);
            end
        end
        piv_val = state.comb[pivot] + EW'(1);
    end

    // Candidate combination: either the first one or the successor.
    always_comb begin
        from_start = restart || !state.started;
        for (int j = 0; j < MAX_K; j++) begin
            if (from_start) begin
                cand[j] = in_use[j] ? (lo + EW'(j)) : '0;
            end else if (!in_use[j] || (IW'(j) < pivot)) begin
                cand[j] = state.comb[j];
            end else begin
                cand[j] = piv_val + (EW'(j) - EW'(pivot));
            end
        end
        fin = 1'b1;
        for (int i = 0; i < MAX_K; i++) begin
            if (in_use[i] && (LW'(cand[i]) != lim[i])) begin
                fin = 1'b0;
            end
        end
    end

    // New state and result.
    always_comb begin
        state_next        = state;
        result.elem       = '0;
        result.final_flag = 1'b0;
        result.status     = 1'b1;
        if (from_start) begin
            state_next.started = 1'b1;
            if (!cfg_ok) begin
                state_next.comb = '0;
                state_next.done = 1'b1;
            end else begin
                state_next.comb = cand;
                state_next.done = fin;
            end
        end else if (state.done || !cfg_ok || !(|can_raise)) begin
            state_next.done = 1'b1;
        end else begin
            state_next.comb = cand;
            state_next.done = fin;
        end

        if (state_next.comb == cand && ((from_start && cfg_ok) ||
            (!from_start && !state.done && cfg_ok && (|can_raise)))) begin
            for (int i = 0; i < MAX_K; i++) begin
                result.elem[i] = in_use[i] ? cand[i] : '0;
            end
            result.final_flag = fin;
            result.status     = 1'b0;
        end
    end

endmodule

@@ hw/rtl/k_combination_generator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_combination_generator_top
// Lexicographic k-combination generator with stream ports and a register port.
// ----------------------------------------------------------------------------
// Each transfer on the s_ channel asks for one combination: s_tdata bit 0 set
// restarts at the first combination, clear advances to the next one. Every
// request yields exactly one transfer on the m_ channel, carrying up to eight
// ascending elements in m_tdata (unused positions zero), m_tlast on the final
// combination and m_tuser set when the sequence is exhausted.
// The successor is found combinationally by parallel compares over the eight
// positions, so one request is taken every clock while the skid register is
// empty; its result is registered into the output or the skid register.
// The output register is backed by a skid register: a stalled receiver holds
// the current result while one more request is still accepted; s_tready falls
// only when both are full.
// Reset returns the registers to n = 4, k = 2, first value 1, and the first
// request after reset starts the sequence. The user must write registers via
// APB (byte addresses 0, 4, 8) only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module k_combination_generator_top
    import kcg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request stream. s_tdata: [0] restart, [7:1] zero.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Result stream. m_tdata: elem_0 [5:0] up to elem_7 [47:42].
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    // m_tuser: [0] status (1 = exhausted).
    output logic                 m_tuser,
    // Register port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    cfg_t       cfg_reg;
    gen_state_t state_reg;
    gen_state_t state_next;
    result_t    res;
    logic       in_acc;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    logic       out_valid_reg, out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    result_t    out_data_reg, out_data_next;
    result_t    skid_data_reg, skid_data_next;

    // Register port decode.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.set_size     <= SET_SIZE_RST;
            cfg_reg.choose_count <= CHOOSE_COUNT_RST;
            cfg_reg.first_value  <= FIRST_VALUE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SET_SIZE:     cfg_reg.set_size     <= pwdata[EW-1:0];
                REG_CHOOSE_COUNT: cfg_reg.choose_count <= pwdata[KW-1:0];
                REG_FIRST_VALUE:  cfg_reg.first_value  <= pwdata[EW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SET_SIZE:     prdata = PDATA_W'(cfg_reg.set_size);
            REG_CHOOSE_COUNT: prdata = PDATA_W'(cfg_reg.choose_count);
            REG_FIRST_VALUE:  prdata = PDATA_W'(cfg_reg.first_value);
            default:          prdata = '0;
        endcase
    end

    // Combination step.
    assign s_tready = !skid_valid_reg;
    assign in_acc   = s_tvalid && s_tready;

    kcg_successor u_successor (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .restart    (s_tdata[0]),
        .state_next (state_next),
        .result     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_acc) begin
            state_reg <= state_next;
        end
    end

    // Output register with skid register behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (in_acc) begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (in_acc) begin
            skid_data_next  = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg.elem);
    assign m_tlast  = out_data_reg.final_flag;
    assign m_tuser  = out_data_reg.status;

    // Assertions.
    `ASSERT_IMPLIES(a_exhausted_empty, aclk, aresetn,
        out_valid_reg && out_data_reg.status,
        (out_data_reg.elem == '0) && !out_data_reg.final_flag)
    `ASSERT_IMPLIES(a_skid_behind_out, aclk, aresetn,
        skid_valid_reg, out_valid_reg)
    `ASSERT_IMPLIES(a_done_stays_exhausted, aclk, aresetn,
        in_acc && !s_tdata[0] && state_reg.done, res.status)
    `ASSERT_NEXT(a_final_sets_done, aclk, aresetn,
        in_acc && res.final_flag, state_reg.done)

endmodule

@@ tb/kcg_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcg_tb_pkg
// Scoreboard for the k-combination generator testbench. It tracks the
// register settings and the stored combination, works out the combination
// due for each accepted request, and compares every result transfer against
// the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
package kcg_tb_pkg;

    import kcg_pkg::*;

    class combination_scoreboard;

        // Register copies, held at the widths of the block's registers.
        logic [EW-1:0] set_size;
        logic [KW-1:0] choose_count;
        logic [EW-1:0] first_value;

        // Generator state as the block should hold it.
        int comb [MAX_K];
        bit started;
        bit done;

        result_t expected_combos [$];
        int      mismatch_count;

        function new();
            set_size       = SET_SIZE_RST;
            choose_count   = CHOOSE_COUNT_RST;
            first_value    = FIRST_VALUE_RST;
            foreach (comb[i]) comb[i] = 0;
            started        = 1'b0;
            done           = 1'b0;
            mismatch_count = 0;
        endfunction

        // A register write lands; only the register's own width is kept.
        function void apply_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_SET_SIZE:     set_size     = value[EW-1:0];
                REG_CHOOSE_COUNT: choose_count = value[KW-1:0];
                REG_FIRST_VALUE:  first_value  = value[EW-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_combos.size();
        endfunction

        function bit sequence_finished();
            return done;
        endfunction

        // Exhausted answer: no elements, no final flag, and the sequence ends.
        function void push_exhausted();
            result_t r;
            r        = '0;
            r.status = 1'b1;
            done     = 1'b1;
            expected_combos = {expected_combos, r};
        endfunction

        // An accepted request: derive the combination it yields.
        function void note_request(bit restart);
            int      n;
            int      k;
            int      lo;
            int      avail;
            int      i;
            bit      cfg_ok;
            bit      last;
            result_t r;

            // Saturate n, map a first value of zero to one.
            n      = (set_size > MAX_N) ? MAX_N : int'(set_size);
            k      = choose_count;
            lo     = (first_value == 0) ? 1 : int'(first_value);
            avail  = (n >= lo) ? n - lo + 1 : 0;
            cfg_ok = (k <= MAX_K) && (k <= avail);

            if (restart || !started) begin
                // Start over; an advance before any start behaves the same.
                started = 1'b1;
                done    = 1'b0;
                foreach (comb[j]) comb[j] = 0;
                if (!cfg_ok) begin
                    push_exhausted();
                    return;
                end
                for (int j = 0; j < k; j++) comb[j] = lo + j;
            end else begin
                if (done || !cfg_ok) begin
                    push_exhausted();
                    return;
                end
                // Raise the rightmost position still below its ceiling.
                i = k;
                while (i > 0 && comb[i-1] >= n - k + i) i--;
                if (i == 0) begin
                    push_exhausted();
                    return;
                end
                i--;
                comb[i] = comb[i] + 1;
                for (int j = i + 1; j < k; j++) comb[j] = comb[i] + (j - i);
            end

            // The last combination is the top k values in order.
            last = 1'b1;
            for (int j = 0; j < k; j++)
                if (comb[j] != n - k + 1 + j) last = 1'b0;
            if (last) done = 1'b1;

            r = '0;
            for (int j = 0; j < k; j++) r.elem[j] = comb[j][EW-1:0];
            r.final_flag = last;
            expected_combos = {expected_combos, r};
        endfunction

        function void report(string field, int expected_v, int actual_v);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("tb: %s mismatch, expected %0d, got %0d",
                         field, expected_v, actual_v);
        endfunction

        // A result transfer: compare it with the oldest expectation.
        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tlast,
                                   logic tuser);
            result_t got;
            result_t want;

            got.elem       = tdata[MAX_K*EW-1:0];
            got.final_flag = tlast;
            got.status     = tuser;
            if (expected_combos.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("tb: result with no request outstanding, data %h",
                             tdata);
                return;
            end
            want = expected_combos.pop_front();
            for (int j = 0; j < MAX_K; j++)
                if (got.elem[j] !== want.elem[j])
                    report($sformatf("elem_%0d", j), want.elem[j], got.elem[j]);
            if (got.final_flag !== want.final_flag)
                report("final_flag", want.final_flag, got.final_flag);
            if (got.status !== want.status)
                report("status", want.status, got.status);
        endfunction

    endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for k_combination_generator_top. A directed run walks
// the special cases (advance before start, exhaustion, empty subsets,
// saturation, registers changed mid-sequence), then random phases of
// requests under random register settings, with random gaps on the request
// side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;

    import kcg_pkg::*;
    import kcg_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_LIMIT  = 2000;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    combination_scoreboard sb;
    bit                    burst = 1'b0;
    int                    items_sent;

    k_combination_generator_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // One request transfer, after a random gap unless in a burst.
    task automatic send_request(bit restart);
        if (!burst) begin
            while ($urandom_range(0, 99) < 34) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(restart);
        do @(posedge aclk); while (!s_tready);
        sb.note_request(restart);
        items_sent++;
    endtask

    // Hold off requests until every outstanding result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic apb_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.apply_write(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(logic [PDATA_W-1:0] n, logic [PDATA_W-1:0] k,
                             logic [PDATA_W-1:0] lo);
        drain();
        apb_write(REG_SET_SIZE, n);
        apb_write(REG_CHOOSE_COUNT, k);
        apb_write(REG_FIRST_VALUE, lo);
    endtask

    // Random bits above a register's width, which the block must drop.
    function automatic logic [PDATA_W-1:0] with_junk(int value, int w);
        return (PDATA_W'($urandom) << w) | PDATA_W'(value);
    endfunction

    // Result side: check each transfer, stall at random outside bursts.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, m_tuser);
            m_tready <= burst || ($urandom_range(0, 99) >= 34);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // Stimulus.
    initial begin
        int  lo;
        int  avail;
        int  k_top;
        int  phase_len;
        bit  restart;

        sb         = new();
        items_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings n = 4, k = 2: an advance before any start, the whole
        // sequence to its final combination, one exhausted request, a restart.
        repeat (7) send_request(1'b0);
        send_request(1'b1);

        // k of zero gives one empty combination, then exhaustion.
        configure(4, 0, 1);
        send_request(1'b1);
        send_request(1'b0);

        // Set size above the limit saturates; a first value of zero means one.
        configure(63, 8, 0);
        send_request(1'b1);
        send_request(1'b0);

        // A single value at the very top of the range.
        configure(32, 1, 32);
        send_request(1'b1);
        send_request(1'b0);

        // k above the maximum, an empty range and the largest first value.
        configure(0, 15, 63);
        send_request(1'b1);
        send_request(1'b0);

        // k larger than the values available.
        configure(25, 2, 25);
        send_request(1'b1);

        // Registers changed in the middle of a sequence, with no restart.
        configure(6, 3, 1);
        send_request(1'b1);
        send_request(1'b0);
        drain();
        apb_write(REG_CHOOSE_COUNT, 5);
        send_request(1'b0);
        send_request(1'b0);
        drain();
        apb_write(REG_SET_SIZE, 3);
        send_request(1'b0);

        // Random phases, each under fresh register settings.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            burst = (items_sent >= 600 && items_sent < 900);
            drain();
            case ($urandom_range(0, 9))
                0: begin
                    // Anything at all, upper bits included.
                    apb_write(REG_SET_SIZE, $urandom);
                    apb_write(REG_CHOOSE_COUNT, $urandom);
                    apb_write(REG_FIRST_VALUE, $urandom);
                end
                1: begin
                    // One register moved while a sequence is under way.
                    case ($urandom_range(0, 2))
                        0: apb_write(REG_SET_SIZE, $urandom_range(0, 12));
                        1: apb_write(REG_CHOOSE_COUNT, $urandom_range(0, 8));
                        default: apb_write(REG_FIRST_VALUE, $urandom_range(0, 6));
                    endcase
                end
                default: begin
                    // Mostly short sequences that run to their end.
                    lo    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32)
                                                        : $urandom_range(1, 4);
                    avail = $urandom_range(0, 9);
                    k_top = (avail < MAX_K) ? avail : MAX_K;
                    if ($urandom_range(0, 7) == 0) k_top = k_top + 1;
                    apb_write(REG_SET_SIZE, with_junk(lo + avail - 1, EW));
                    apb_write(REG_CHOOSE_COUNT, with_junk($urandom_range(0, k_top), KW));
                    apb_write(REG_FIRST_VALUE, with_junk(lo, EW));
                end
            endcase
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
                restart = (sb.sequence_finished() && $urandom_range(0, 2) == 0)
                          || ($urandom_range(0, 39) == 0);
                send_request(restart);
            end
        end
        burst = 1'b0;

        // Let the last results out, then watch for strays.
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
